[design/pdms_pkg.sv]
package pdms_pkg;

  // Widths fixed by the request and result formats.
  localparam int FREQ_W = 26;
  localparam int HINT_W = 8;
  localparam int SEL_W  = 5;
  // Product of a 26-bit input clock and a multiplier of at most 16.
  localparam int ACC_W  = FREQ_W + 4;
  localparam int CNT_W  = $clog2(FREQ_W);

  // Internal 8 MHz oscillator halved ahead of the PLL.
  localparam logic [FREQ_W-1:0] HALF_INTERNAL_HZ = 26'd4000000;

  localparam logic [FREQ_W-1:0] MAX_SYSCLK_RST = 26'd48000000;
  localparam logic [FREQ_W-1:0] WAIT_THR_RST   = 26'd24000000;

  // Register index, taken from bit 2 of the byte address.
  localparam logic REG_MAX_SYSCLK = 1'b0;
  localparam logic REG_WAIT_THR   = 1'b1;

  // Clock source selector.
  localparam logic SRC_INTERNAL = 1'b0;

  typedef struct packed {
    logic              done;
    logic [FREQ_W-1:0] quot;
  } div_res_t;

  typedef struct packed {
    logic             done;
    logic             hit;
    logic [SEL_W-1:0] mult;
  } mul_res_t;

endpackage

[design/pdms_div.sv]
module pdms_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [pdms_pkg::FREQ_W-1:0]   dividend,
  input  logic [pdms_pkg::SEL_W-1:0]    divisor,
  output pdms_pkg::div_res_t            res
);
  import pdms_pkg::*;

  localparam logic [CNT_W-1:0] LAST = CNT_W'(FREQ_W - 1);

  logic              busy;
  logic              done;
  logic [CNT_W-1:0]  cnt;
  logic [SEL_W-1:0]  rem;
  logic [FREQ_W-1:0] quo;
  logic [SEL_W:0]    trial;
  logic              fits;

  // Restoring division, one quotient bit per cycle, MSB first.
  assign trial = {rem, quo[FREQ_W-1]};
  assign fits  = trial >= {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        rem  <= '0;
        quo  <= dividend;
      end else if (busy) begin
        rem <= fits ? SEL_W'(trial - {1'b0, divisor}) : trial[SEL_W-1:0];
        quo <= {quo[FREQ_W-2:0], fits};
        cnt <= cnt + 1'b1;
        if (cnt == LAST) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign res.done = done;
  assign res.quot = quo;

endmodule

[design/pdms_mul.sv]
module pdms_mul #(
  parameter int MULT_MAX = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [pdms_pkg::FREQ_W-1:0]   fin,
  input  logic [pdms_pkg::FREQ_W-1:0]   target,
  output pdms_pkg::mul_res_t            res
);
  import pdms_pkg::*;

  localparam logic [SEL_W-1:0] M_LAST = SEL_W'(MULT_MAX);

  logic              busy;
  logic              done;
  logic              hit;
  logic [SEL_W-1:0]  m;
  logic [ACC_W-1:0]  acc;
  logic [FREQ_W-1:0] fin_q;
  logic [ACC_W-1:0]  tgt_ext;

  assign tgt_ext = ACC_W'(target);

  // The product fin*m is built by repeated addition; since it only grows,
  // the walk stops as soon as it passes the target.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      hit  <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        fin_q <= fin;
        acc   <= ACC_W'({fin, 1'b0});
        m     <= SEL_W'(2);
      end else if (busy) begin
        if (acc == tgt_ext) begin
          busy <= 1'b0;
          done <= 1'b1;
          hit  <= 1'b1;
        end else if (m == M_LAST || acc > tgt_ext) begin
          busy <= 1'b0;
          done <= 1'b1;
          hit  <= 1'b0;
        end else begin
          acc <= acc + ACC_W'(fin_q);
          m   <= m + 1'b1;
        end
      end
    end
  end

  assign res.done = done;
  assign res.hit  = hit;
  assign res.mult = m;

endmodule

[design/pll_divider_multiplier_search.sv]
// Channel   Direction  Handshake                  Payload
// s_*       in         s_tvalid / s_tready        s_tdata: hse_hz, target_hz, div_hint
//                                                 s_tuser: func
// m_*       out        m_tvalid / m_tready        m_tdata: found, prediv, pll_mult, flash_wait
// APB       in         psel, penable, pwrite      paddr, pwdata, prdata, pready
//
// An instant failure goes straight to the output stage, the internal source runs only the
// multiplier walk and a fixed pre-divider runs one bit-serial divide of hse_hz and one walk;
// a full search repeats the divide and the walk for each pre-divider in turn until one hits.
// Reset (rst, synchronous) restores the register defaults and empties the output stage.
// A new request is taken while a result still waits; the search then holds before
// its last step until the waiting result has been taken.
module pll_divider_multiplier_search #(
  parameter int PREDIV_MAX = 16,
  parameter int MULT_MAX   = 16
) (
  input  logic        clk,
  input  logic        rst,
  // APB configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // Requests
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,  // [25:0] hse_hz, [51:26] target_hz, [59:52] div_hint
  input  logic [0:0]  s_tuser,  // [0] func
  // Results
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata   // [0] found, [5:1] prediv, [10:6] pll_mult, [11] flash_wait
);
  import pdms_pkg::*;

  localparam logic [SEL_W-1:0]  PRE_LAST = SEL_W'(PREDIV_MAX);
  localparam logic [HINT_W-1:0] HINT_MAX = HINT_W'(PREDIV_MAX);

  typedef enum logic [1:0] {
    S_IDLE,
    S_DIV,
    S_MUL,
    S_FINISH
  } state_t;

  state_t            state;
  logic [FREQ_W-1:0] max_sysclk;
  logic [FREQ_W-1:0] wait_thr;

  // Request fields held for the whole search.
  logic [FREQ_W-1:0] hse;
  logic [FREQ_W-1:0] target;
  logic [SEL_W-1:0]  pre;
  logic              single;
  logic              ok;
  logic [SEL_W-1:0]  mult;
  logic [FREQ_W-1:0] fin;
  logic              div_start;
  logic              mul_start;

  // Output register.
  logic              out_valid;
  logic              out_found;
  logic [SEL_W-1:0]  out_pre;
  logic [SEL_W-1:0]  out_mult;
  logic              out_wait;

  div_res_t          div_res;
  mul_res_t          mul_res;

  logic              s_xfer;
  logic              cfg_wr;
  logic [FREQ_W-1:0] in_hse;
  logic [FREQ_W-1:0] in_target;
  logic [HINT_W-1:0] in_hint;
  logic              in_fail;
  logic              hint_fixed;
  logic              out_free;

  assign in_hse    = s_tdata[25:0];
  assign in_target = s_tdata[51:26];
  assign in_hint   = s_tdata[59:52];

  assign s_tready = (state == S_IDLE);
  assign s_xfer   = s_tvalid && s_tready;
  assign out_free = !out_valid || m_tready;

  // A zero target, a target above the limit, or a missing external clock fails at once.
  assign in_fail = (in_target == '0) || (in_target > max_sysclk) ||
                   ((s_tuser[0] != SRC_INTERNAL) && (in_hse == '0));
  assign hint_fixed = (in_hint >= HINT_W'(1)) && (in_hint <= HINT_MAX);

  // Configuration registers; software must write them only while no request is in flight (not enforced here).
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = (paddr[2] == REG_WAIT_THR) ? 32'(wait_thr) : 32'(max_sysclk);

  always_ff @(posedge clk) begin
    if (rst) begin
      max_sysclk <= MAX_SYSCLK_RST;
      wait_thr   <= WAIT_THR_RST;
    end else if (cfg_wr) begin
      if (paddr[2] == REG_MAX_SYSCLK) begin
        max_sysclk <= pwdata[FREQ_W-1:0];
      end else begin
        wait_thr <= pwdata[FREQ_W-1:0];
      end
    end
  end

  pdms_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (hse),
    .divisor  (pre),
    .res      (div_res)
  );

  pdms_mul #(
    .MULT_MAX (MULT_MAX)
  ) u_mul (
    .clk    (clk),
    .rst    (rst),
    .start  (mul_start),
    .fin    (fin),
    .target (target),
    .res    (mul_res)
  );

  // Sequencer. The internal source tries 4 MHz directly with a pre-divider of one.
  // The external source divides hse_hz by the current pre-divider, then walks the
  // multipliers; on a miss the search moves to the next pre-divider unless the
  // hint fixed it.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      div_start <= 1'b0;
      mul_start <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      div_start <= 1'b0;
      mul_start <= 1'b0;
      if (out_valid && m_tready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (s_xfer) begin
            hse    <= in_hse;
            target <= in_target;
            ok     <= 1'b0;
            mult   <= '0;
            if (in_fail) begin
              pre   <= '0;
              state <= S_FINISH;
            end else if (s_tuser[0] == SRC_INTERNAL) begin
              pre       <= SEL_W'(1);
              fin       <= HALF_INTERNAL_HZ;
              single    <= 1'b1;
              mul_start <= 1'b1;
              state     <= S_MUL;
            end else begin
              pre       <= hint_fixed ? in_hint[SEL_W-1:0] : SEL_W'(1);
              single    <= hint_fixed;
              div_start <= 1'b1;
              state     <= S_DIV;
            end
          end
        end
        S_DIV: begin
          if (div_res.done) begin
            fin       <= div_res.quot;
            mul_start <= 1'b1;
            state     <= S_MUL;
          end
        end
        S_MUL: begin
          if (mul_res.done) begin
            if (mul_res.hit) begin
              ok    <= 1'b1;
              mult  <= mul_res.mult;
              state <= S_FINISH;
            end else if (single || pre == PRE_LAST) begin
              state <= S_FINISH;
            end else begin
              pre       <= pre + 1'b1;
              div_start <= 1'b1;
              state     <= S_DIV;
            end
          end
        end
        S_FINISH: begin
          if (out_free) begin
            out_valid <= 1'b1;
            out_found <= ok;
            out_pre   <= ok ? pre : '0;
            out_mult  <= ok ? mult : '0;
            out_wait  <= ok && (target > wait_thr);
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {4'b0, out_wait, out_mult, out_pre, out_found};

`ifndef SYNTHESIS
  // A found result always carries a usable pre-divider and multiplier.
  a_found_fields: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[0]) |-> (m_tdata[5:1] != 5'd0 && m_tdata[10:6] >= 5'd2))
    else $error("found result with an invalid pre-divider or multiplier");

  // A failed result reports nothing else.
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tdata[0]) |-> (m_tdata[11:1] == 11'd0))
    else $error("failed result carries nonzero fields");

  // The divider only finishes while the sequencer waits for it.
  a_div_owner: assert property (@(posedge clk) disable iff (rst)
    div_res.done |-> (state == S_DIV))
    else $error("divider finished outside the divide step");

  // The multiplier walk only finishes while the sequencer waits for it.
  a_mul_owner: assert property (@(posedge clk) disable iff (rst)
    mul_res.done |-> (state == S_MUL))
    else $error("multiplier walk finished outside the multiply step");
`endif

endmodule

[bench/tb_top.sv]
`timescale 1ns / 100ps

// Testbench for the PLL pre-divider / multiplier planner.
//
// Requests go in on the s_* stream and every accepted transfer yields exactly
// one result on the m_* stream. The bench keeps its own copy of the two
// configuration registers and an in-order queue of predicted plans. The result
// monitor pops the oldest plan for each result transfer and compares it field
// by field.
module tb_top;
  import pdms_pkg::*;

  localparam int PREDIV_MAX = 16;
  localparam int MULT_MAX   = 16;

  // Source selector values on s_tuser.
  localparam logic SRC_EXTERNAL = ~SRC_INTERNAL;

  localparam logic [FREQ_W-1:0] FREQ_ALL_ONES = '1;
  localparam int unsigned       HSE_TOP_HZ    = 50000000;

  // The quiet period at the end of the run outlasts a full search over sixteen
  // pre-dividers, and the drain before register writes waits out every search.
  localparam int SETTLE_CYCLES = 16;
  localparam int TAIL_CYCLES   = 1000;
  localparam int PHASE_ITEMS   = 106;
  localparam int MAX_REPORTS   = 10;

  typedef struct packed {
    logic             found;
    logic [SEL_W-1:0] prediv;
    logic [SEL_W-1:0] mult;
    logic             flash_wait;
  } plan_t;

  logic        clk;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  logic        s_tvalid;
  logic        s_tready;
  logic [63:0] s_tdata;
  logic [0:0]  s_tuser;
  logic        m_tvalid;
  logic        m_tready;
  logic [15:0] m_tdata;

  // Bench copies of the configuration registers.
  logic [FREQ_W-1:0] max_sysclk_cfg;
  logic [FREQ_W-1:0] wait_thr_cfg;

  // Predicted plans, oldest first.
  plan_t plan_q[$];
  int    fail_count;

  // Sender burst bookkeeping.
  int burst_left;

  pll_divider_multiplier_search #(
    .PREDIV_MAX(PREDIV_MAX),
    .MULT_MAX  (MULT_MAX)
  ) DUT (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),   // [25:0] hse_hz, [51:26] target_hz, [59:52] div_hint
    .s_tuser (s_tuser),   // [0] func
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata)    // [0] found, [5:1] prediv, [10:6] pll_mult, [11] flash_wait
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // Plan computation for one request under the current register copies.
  // The internal source rounds target/4 MHz to the nearest multiplier and
  // keeps it only if it is in range and exact. The external source walks
  // either the single hinted pre-divider or all of them, and for each one
  // the multipliers in ascending order; the first exact product wins.
  function automatic plan_t plan_pll(input logic func, input logic [FREQ_W-1:0] hse,
                                     input logic [FREQ_W-1:0] target,
                                     input logic [HINT_W-1:0] hint);
    plan_t       plan;
    int unsigned m;
    int unsigned p;
    int unsigned p_lo;
    int unsigned p_hi;
    int unsigned fin;
    bit          hit;
    plan = '0;
    hit  = 1'b0;
    if (target != 0 && target <= max_sysclk_cfg) begin
      if (func == SRC_INTERNAL) begin
        m = (32'(target) + 32'(HALF_INTERNAL_HZ) / 2) / 32'(HALF_INTERNAL_HZ);
        if (m >= 2 && m <= MULT_MAX && longint'(HALF_INTERNAL_HZ) * m == longint'(target)) begin
          hit         = 1'b1;
          plan.prediv = SEL_W'(1);
          plan.mult   = SEL_W'(m);
        end
      end else if (hse != 0) begin
        if (hint >= 1 && hint <= PREDIV_MAX) begin
          p_lo = hint;
          p_hi = hint;
        end else begin
          p_lo = 1;
          p_hi = PREDIV_MAX;
        end
        for (p = p_lo; p <= p_hi && !hit; p++) begin
          fin = 32'(hse) / p;
          for (m = 2; m <= MULT_MAX && !hit; m++) begin
            if (longint'(fin) * m == longint'(target)) begin
              hit         = 1'b1;
              plan.prediv = SEL_W'(p);
              plan.mult   = SEL_W'(m);
            end
          end
        end
      end
    end
    if (hit) begin
      plan.found      = 1'b1;
      plan.flash_wait = (target > wait_thr_cfg);
    end
    return plan;
  endfunction

  // Result monitor: every result transfer is checked against the oldest plan.
  always @(posedge clk) begin
    plan_t want;
    plan_t got;
    if (!rst && m_tvalid === 1'b1 && m_tready) begin
      got.found      = m_tdata[0];
      got.prediv     = m_tdata[5:1];
      got.mult       = m_tdata[10:6];
      got.flash_wait = m_tdata[11];
      if (plan_q.size() == 0) begin
        fail_count++;
        if (fail_count <= MAX_REPORTS)
          $display("%0t: result with nothing pending: found=%0d prediv=%0d mult=%0d wait=%0d",
                   $realtime, got.found, got.prediv, got.mult, got.flash_wait);
      end else begin
        want = plan_q.pop_front();
        if (got.found !== want.found || got.prediv !== want.prediv ||
            got.mult !== want.mult || got.flash_wait !== want.flash_wait) begin
          fail_count++;
          if (fail_count <= MAX_REPORTS)
            $display({"%0t: plan mismatch: expected found=%0d prediv=%0d mult=%0d wait=%0d,",
                      " got found=%0d prediv=%0d mult=%0d wait=%0d"},
                     $realtime, want.found, want.prediv, want.mult, want.flash_wait,
                     got.found, got.prediv, got.mult, got.flash_wait);
        end
      end
    end
  end

  // Receiver: m_tready follows a pattern that is picked anew at random after each
  // run of random length: always ready, coin flips, one cycle in five, or long stalls.
  initial begin
    int rx_mode;
    int rx_left;
    int rx_stall;
    m_tready = 1'b0;
    rx_mode  = 0;
    rx_left  = 0;
    rx_stall = 0;
    forever begin
      @(negedge clk);
      if (rx_left == 0) begin
        rx_mode = $urandom_range(0, 3);
        rx_left = $urandom_range(50, 400);
      end
      rx_left--;
      case (rx_mode)
        0: m_tready <= 1'b1;
        1: m_tready <= 1'($urandom_range(0, 1));
        2: m_tready <= (rx_left % 5 == 0);
        default: begin
          if (rx_stall > 0) begin
            m_tready <= 1'b0;
            rx_stall--;
          end else begin
            m_tready <= 1'b1;
            if ($urandom_range(0, 7) == 0)
              rx_stall = $urandom_range(10, 60);
          end
        end
      endcase
    end
  end

  // One request transfer. The plan is predicted once the transfer is taken,
  // using the register values that the block holds at that point. Valid is
  // left high so that a following request can go out back to back.
  task automatic send_request(input logic func, input logic [FREQ_W-1:0] hse,
                              input logic [FREQ_W-1:0] target,
                              input logic [HINT_W-1:0] hint);
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tdata  <= {4'b0, hint, target, hse};
    s_tuser  <= func;
    do @(posedge clk); while (!s_tready);
    plan_q.push_back(plan_pll(func, hse, target, hint));
  endtask

  // Sender pacing: bursts of random length, separated by gaps that are
  // usually short, sometimes absent and now and then longer than a search.
  task automatic pace_sender();
    int gap;
    if (burst_left == 0) begin
      case ($urandom_range(0, 9))
        0, 1, 2: gap = 0;
        3:       gap = $urandom_range(30, 800);
        default: gap = $urandom_range(1, 25);
      endcase
      if (gap > 0) begin
        @(negedge clk);
        s_tvalid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
      burst_left = $urandom_range(1, 20);
    end
    burst_left--;
  endtask

  // Stop sending and wait until every predicted plan has been matched.
  task automatic drain_results();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (plan_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // APB write: setup cycle, then access cycle until pready. Unused upper
  // data bits carry noise, since the block keeps only the low 26 bits.
  task automatic write_reg(input logic reg_sel, input logic [FREQ_W-1:0] value);
    logic [31:0] word;
    word = ($urandom() & 32'hFC00_0000) | 32'(value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {reg_sel, 2'b00};
    pwdata  <= word;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (reg_sel == REG_MAX_SYSCLK)
      max_sysclk_cfg = word[FREQ_W-1:0];
    else
      wait_thr_cfg = word[FREQ_W-1:0];
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic set_limits(input logic [FREQ_W-1:0] max_hz, input logic [FREQ_W-1:0] thr_hz);
    drain_results();
    write_reg(REG_MAX_SYSCLK, max_hz);
    write_reg(REG_WAIT_THR, thr_hz);
  endtask

  // Directed requests under the reset values of the registers (48 MHz limit,
  // 24 MHz wait-state threshold).
  task automatic test_reset_limits();
    // Zero target, then exact internal multiples at both ends of the range.
    send_request(SRC_INTERNAL, 26'd0, 26'd0, 8'd0);
    send_request(SRC_INTERNAL, 26'd12345, 26'd8000000, 8'd3);
    send_request(SRC_INTERNAL, 26'd0, 26'd48000000, 8'd0);
    // Multiplier of one, an inexact target that rounds to two, and one above
    // the limit, all refused.
    send_request(SRC_INTERNAL, 26'd0, 26'd4000000, 8'd0);
    send_request(SRC_INTERNAL, 26'd0, 26'd6000000, 8'd0);
    send_request(SRC_INTERNAL, 26'd0, 26'd52000000, 8'd0);
    // Target equal to the threshold needs no wait state; the external
    // oscillator field and the hint are ignored for the internal source.
    send_request(SRC_INTERNAL, 26'(HSE_TOP_HZ), 26'd24000000, 8'hFF);
    // External source with no oscillator frequency.
    send_request(SRC_EXTERNAL, 26'd0, 26'd8000000, 8'd0);
    // Fixed pre-dividers at one and at the top of the range.
    send_request(SRC_EXTERNAL, 26'd8000000, 26'd48000000, 8'd1);
    send_request(SRC_EXTERNAL, 26'(HSE_TOP_HZ), 26'd46875000, 8'd16);
    // Searches started by a zero hint, a hint just past the range and 0xFF.
    send_request(SRC_EXTERNAL, 26'd12000000, 26'd36000000, 8'd0);
    send_request(SRC_EXTERNAL, 26'd25000000, 26'd40000000, 8'd17);
    send_request(SRC_EXTERNAL, 26'd25000000, 26'd48000000, 8'hFF);
    // One hertz above the limit, and a hinted divide that truncates.
    send_request(SRC_EXTERNAL, 26'd8000000, 26'd48000001, 8'd1);
    send_request(SRC_EXTERNAL, 26'd8000003, 26'd42666672, 8'd3);
    send_request(SRC_EXTERNAL, 26'd1, 26'd2, 8'd0);
  endtask

  // Directed requests at the extreme register settings.
  task automatic test_limit_extremes();
    // Widest limit, every accepted target needs a wait state.
    set_limits(FREQ_ALL_ONES, 26'd0);
    send_request(SRC_INTERNAL, 26'd0, 26'd64000000, 8'd0);
    send_request(SRC_EXTERNAL, 26'(HSE_TOP_HZ), FREQ_ALL_ONES, 8'd0);
    send_request(SRC_EXTERNAL, 26'd33554432, 26'd33554432, 8'd16);
    // Narrowest limit of one hertz: nothing can be reached.
    set_limits(26'd1, FREQ_ALL_ONES);
    send_request(SRC_EXTERNAL, 26'd1, 26'd1, 8'd1);
    send_request(SRC_INTERNAL, 26'd0, 26'd1, 8'd0);
    send_request(SRC_EXTERNAL, 26'd1, 26'd2, 8'd0);
    // Widest limit with the threshold at the top: never a wait state.
    set_limits(FREQ_ALL_ONES, FREQ_ALL_ONES);
    send_request(SRC_INTERNAL, 26'd0, 26'd64000000, 8'd0);
  endtask

  // One random request. Most are built to have an exact answer so that the
  // fixed and searched paths are reached with random content; the rest are
  // near misses, raw noise and the boundary cases of the limit.
  task automatic send_random_request();
    int                unsigned m;
    int                unsigned p;
    logic              func;
    logic [FREQ_W-1:0] hse;
    logic [FREQ_W-1:0] target;
    logic [HINT_W-1:0] hint;
    func   = 1'($urandom_range(0, 1));
    hse    = 26'($urandom_range(0, HSE_TOP_HZ));
    target = 26'($urandom());
    hint   = 8'($urandom());
    case ($urandom_range(0, 9))
      0, 1, 2: begin
        func   = SRC_INTERNAL;
        m      = $urandom_range(0, MULT_MAX + 1);
        target = 26'(m * 32'(HALF_INTERNAL_HZ));
        // Off-grid targets exercise the rounding step.
        if ($urandom_range(0, 3) == 0)
          target = 26'(32'(target) + $urandom_range(1, 2500000));
        else if ($urandom_range(0, 3) == 0)
          target = 26'(32'(target) - $urandom_range(1, 2500000));
      end
      3, 4, 5, 6: begin
        func = SRC_EXTERNAL;
        if ($urandom_range(0, 1) == 0)
          hse = 26'($urandom_range(1, HSE_TOP_HZ));
        else
          hse = 26'($urandom_range(1, 50) * 1000000);
        p      = $urandom_range(1, PREDIV_MAX);
        m      = $urandom_range(2, MULT_MAX);
        target = 26'((32'(hse) / p) * m);
        case ($urandom_range(0, 3))
          0, 1: hint = 8'(p);
          2:    hint = 8'($urandom_range(1, PREDIV_MAX));
          default: hint = ($urandom_range(0, 1) == 0) ? 8'd0 : 8'($urandom_range(17, 255));
        endcase
      end
      7: begin
        func = SRC_EXTERNAL;
        hint = 8'd0;
      end
      8: ;
      default: begin
        case ($urandom_range(0, 3))
          0: target = 26'd0;
          1: target = max_sysclk_cfg;
          2: target = max_sysclk_cfg + 26'd1;
          default: begin
            func = SRC_EXTERNAL;
            hse  = 26'd0;
          end
        endcase
      end
    endcase
    send_request(func, hse, target, hint);
  endtask

  // Random phases, each under a different pair of register values. The
  // drain before each register write also makes the sender wait until every
  // pending result has been transferred.
  task automatic test_random_phases();
    int                phase;
    int                n;
    logic [FREQ_W-1:0] max_hz;
    for (phase = 0; phase < 5; phase++) begin
      case (phase)
        0: set_limits(MAX_SYSCLK_RST, WAIT_THR_RST);
        1: set_limits(FREQ_ALL_ONES, 26'($urandom()));
        2: set_limits(26'($urandom_range(1, 32'(FREQ_ALL_ONES))), 26'($urandom()));
        3: set_limits(FREQ_ALL_ONES, 26'd0);
        default: begin
          max_hz = 26'($urandom_range(8000000, 48000000));
          set_limits(max_hz, 26'($urandom_range(0, 32'(max_hz))));
        end
      endcase
      burst_left = 0;
      for (n = 0; n < PHASE_ITEMS; n++) begin
        pace_sender();
        send_random_request();
      end
    end
  endtask

  initial begin
    rst            = 1'b1;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    s_tvalid       = 1'b0;
    s_tdata        = '0;
    s_tuser        = '0;
    max_sysclk_cfg = MAX_SYSCLK_RST;
    wait_thr_cfg   = WAIT_THR_RST;
    fail_count     = 0;
    burst_left     = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_reset_limits();
    test_limit_extremes();
    test_random_phases();

    // Let every pending result arrive, then watch for stray transfers for
    // longer than the slowest search.
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (plan_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0 && plan_q.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Watchdog, several times the slowest legal run.
  initial begin
    #60000000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
